[rtl/twrm_pkg.sv]
// Package for the three-wire register master: sequence phases, control
// struct, operation codes and the RSSI gain table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package twrm_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int READ_BITS_DEF = 16;
  localparam int FIELD_WORD_W  = 32;
  localparam int FIELD_READ_W  = 16;
  localparam int RSSI_W        = 7;
  localparam int OP_W          = 2;
  localparam int SEL_W         = 5;

  localparam logic [OP_W-1:0] OP_IDLE  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Low nibble of the readback setup word
  localparam logic [3:0] SEL_TAIL = 4'h7;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_WLOW  = 4'd1,
    PH_WHIGH = 4'd2,
    PH_WEND  = 4'd3,
    PH_LAT1  = 4'd4,
    PH_LAT2  = 4'd5,
    PH_LAT3  = 4'd6,
    PH_LAT4  = 4'd7,
    PH_RSET  = 4'd8,
    PH_DHIGH = 4'd9,
    PH_DLOW  = 4'd10,
    PH_RHIGH = 4'd11,
    PH_RLOW  = 4'd12,
    PH_THIGH = 4'd13,
    PH_TLOW  = 4'd14,
    PH_REND  = 4'd15
  } phase_t;

  typedef struct packed {
    phase_t phase;
    logic   pending;
    logic   pin_clk;
    logic   pin_data;
    logic   pin_le;
  } ctl_t;

  // Gain correction, indexed by bits 11..8 of the doubled readback value
  function automatic logic [7:0] gain_of(input logic [3:0] idx);
    logic [7:0] g;
    case (idx)
      4'd0:    g = 8'd172;
      4'd4:    g = 8'd116;
      4'd5:    g = 8'd76;
      4'd6:    g = 8'd48;
      default: g = 8'd0;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

[rtl/three_wire_register_master_rssi_top.sv]
// Top level of the three-wire register master with RSSI readback.
// Depends on twrm_pkg, twrm_step and twrm_rssi.
`timescale 1ns / 1ps
`default_nettype none

// Each input beat is one pin-update tick of a three-wire serial sequence and
// yields exactly one output beat carrying the pin levels after that tick,
// busy and done flags, and the last readback value with its RSSI figure.
// A beat is taken every clock cycle while the output register is empty or
// being drained, so the block sustains one beat per cycle; the output beat is
// registered; the sequencer state and the output register are the only stages.
// A write takes 2*WORD_BITS + 5 ticks; a readback adds 2*READ_BITS + 6 more.
// Operation codes are honoured only while idle; otherwise they are dropped.

module three_wire_register_master_rssi_top
  import twrm_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int READ_BITS = READ_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [31:0] write_word, [36:32] readback_select, [37] serial_in, [39:38] zero
  input  wire logic [39:0] s_tdata,
  // [1:0] operation
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [0] serial_clock, [1] serial_data, [2] latch_enable, [3] busy_res,
  // [4] done_res, [20:5] readback_raw, [27:21] signal_level, [31:28] zero
  output logic      [31:0] m_tdata
);

  localparam int CNT_W = $clog2(((WORD_BITS > READ_BITS) ? WORD_BITS : READ_BITS) + 1);

  ctl_t                    ctl, ctl_next;
  logic [WORD_BITS-1:0]    out_shift, out_shift_next;
  logic [CNT_W-1:0]        cnt, cnt_next;
  logic [READ_BITS-1:0]    in_shift, in_shift_next;
  logic [READ_BITS-1:0]    last_rb, last_rb_next;
  logic                    done;
  logic [FIELD_READ_W-1:0] raw_next;
  logic [RSSI_W-1:0]       rssi_next;
  logic                    accept;

  // Take a beat whenever the output register is free or drains this cycle
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  twrm_step #(
    .WORD_BITS(WORD_BITS),
    .READ_BITS(READ_BITS)
  ) u_step (
    .ctl             (ctl),
    .out_shift       (out_shift),
    .cnt             (cnt),
    .in_shift        (in_shift),
    .last_rb         (last_rb),
    .operation       (s_tuser[1:0]),
    .write_word      (s_tdata[31:0]),
    .readback_select (s_tdata[36:32]),
    .serial_in       (s_tdata[37]),
    .ctl_next        (ctl_next),
    .out_shift_next  (out_shift_next),
    .cnt_next        (cnt_next),
    .in_shift_next   (in_shift_next),
    .last_rb_next    (last_rb_next),
    .done            (done)
  );

  // Short readbacks leave the upper bits of the raw value at zero
  assign raw_next = FIELD_READ_W'(last_rb_next);

  twrm_rssi u_rssi (
    .raw  (raw_next),
    .rssi (rssi_next)
  );

  // Sequencer state: advance only on an accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl       <= '{phase: PH_IDLE, default: 1'b0};
      out_shift <= '0;
      cnt       <= '0;
      in_shift  <= '0;
      last_rb   <= '0;
    end else if (accept) begin
      ctl       <= ctl_next;
      out_shift <= out_shift_next;
      cnt       <= cnt_next;
      in_shift  <= in_shift_next;
      last_rb   <= last_rb_next;
    end
  end

  // Output register: load on accept, hold while the consumer stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {4'b0000, rssi_next, raw_next, done,
                  (ctl_next.phase != PH_IDLE),
                  ctl_next.pin_le, ctl_next.pin_data, ctl_next.pin_clk};
    end
  end

  // Idle leaves both clock and latch low
  a_idle_pins: assert property (@(posedge clk) disable iff (rst)
    (ctl.phase == PH_IDLE) |-> (!ctl.pin_clk && !ctl.pin_le))
    else $error("idle with clock or latch high");

  // Read phases only run under a pending readback
  a_read_pending: assert property (@(posedge clk) disable iff (rst)
    (ctl.phase >= PH_RSET) |-> ctl.pending)
    else $error("read phase without pending readback");

  // Every accepted beat produces an output beat next cycle
  a_accept_out: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted beat without output");

  // A completing tick always returns the sequencer to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && done) |=> (ctl.phase == PH_IDLE))
    else $error("done without return to idle");

endmodule

`default_nettype wire

[rtl/twrm_rssi.sv]
// RSSI conversion of a raw readback value.
// Depends on twrm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module twrm_rssi
  import twrm_pkg::*;
(
  input  wire logic [FIELD_READ_W-1:0] raw,
  output logic      [RSSI_W-1:0]       rssi
);

  logic [7:0] low_byte;
  logic [3:0] idx;
  logic [8:0] sum;

  // Doubling moves raw[6:0] up one place and raw[10:7] into bits 11..8
  assign low_byte = {raw[6:0], 1'b0};
  assign idx      = raw[10:7];
  assign sum      = {1'b0, low_byte} + {1'b0, gain_of(idx)};
  assign rssi     = sum[8:2];

endmodule

`default_nettype wire

[rtl/twrm_step.sv]
// Next-state logic of the serial sequencer for one tick.
// Depends on twrm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module twrm_step
  import twrm_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int READ_BITS = READ_BITS_DEF,
  localparam int CNT_W = $clog2(((WORD_BITS > READ_BITS) ? WORD_BITS : READ_BITS) + 1)
) (
  input  wire ctl_t                   ctl,
  input  wire logic [WORD_BITS-1:0]   out_shift,
  input  wire logic [CNT_W-1:0]       cnt,
  input  wire logic [READ_BITS-1:0]   in_shift,
  input  wire logic [READ_BITS-1:0]   last_rb,
  input  wire logic [OP_W-1:0]        operation,
  input  wire logic [FIELD_WORD_W-1:0] write_word,
  input  wire logic [SEL_W-1:0]       readback_select,
  input  wire logic                   serial_in,
  output ctl_t                        ctl_next,
  output logic      [WORD_BITS-1:0]   out_shift_next,
  output logic      [CNT_W-1:0]       cnt_next,
  output logic      [READ_BITS-1:0]   in_shift_next,
  output logic      [READ_BITS-1:0]   last_rb_next,
  output logic                        done
);

  logic [FIELD_WORD_W-1:0] sel_word;
  logic [CNT_W-1:0]        cnt_inc;
  phase_t                  cur;

  assign sel_word = {{(FIELD_WORD_W - SEL_W - 4){1'b0}}, readback_select, SEL_TAIL};

  always_comb begin
    ctl_next       = ctl;
    out_shift_next = out_shift;
    cnt_next       = cnt;
    in_shift_next  = in_shift;
    last_rb_next   = last_rb;
    done           = 1'b0;
    cur            = ctl.phase;

    if (cur == PH_IDLE && (operation == OP_WRITE || operation == OP_READ)) begin
      if (operation == OP_WRITE) begin
        out_shift_next   = write_word[WORD_BITS-1:0];
        ctl_next.pending = 1'b0;
      end else begin
        out_shift_next   = sel_word[WORD_BITS-1:0];
        ctl_next.pending = 1'b1;
      end
      cnt_next = '0;
      cur      = PH_WLOW;
    end

    cnt_inc = cnt_next + CNT_W'(1);

    case (cur)
      PH_WLOW: begin
        ctl_next.pin_clk  = 1'b0;
        ctl_next.pin_data = out_shift_next[WORD_BITS-1];
        ctl_next.phase    = PH_WHIGH;
      end
      PH_WHIGH: begin
        ctl_next.pin_clk = 1'b1;
        out_shift_next   = {out_shift_next[WORD_BITS-2:0], 1'b0};
        cnt_next         = cnt_inc;
        ctl_next.phase   = (cnt_inc >= CNT_W'(WORD_BITS)) ? PH_WEND : PH_WLOW;
      end
      PH_WEND: begin
        ctl_next.pin_clk = 1'b0;
        ctl_next.phase   = PH_LAT1;
      end
      PH_LAT1: begin
        ctl_next.pin_le = 1'b1;
        ctl_next.phase  = PH_LAT2;
      end
      PH_LAT2: begin
        ctl_next.pin_le = 1'b1;
        ctl_next.phase  = PH_LAT3;
      end
      PH_LAT3: begin
        ctl_next.pin_data = 1'b0;
        ctl_next.phase    = PH_LAT4;
      end
      PH_LAT4: begin
        ctl_next.pin_le = 1'b0;
        if (ctl_next.pending) begin
          ctl_next.phase = PH_RSET;
        end else begin
          done           = 1'b1;
          ctl_next.phase = PH_IDLE;
        end
      end
      PH_RSET: begin
        ctl_next.pin_data = 1'b0;
        ctl_next.pin_clk  = 1'b0;
        ctl_next.pin_le   = 1'b1;
        in_shift_next     = '0;
        cnt_next          = '0;
        ctl_next.phase    = PH_DHIGH;
      end
      PH_DHIGH: begin
        ctl_next.pin_clk = 1'b1;
        ctl_next.phase   = PH_DLOW;
      end
      PH_DLOW: begin
        ctl_next.pin_clk = 1'b0;
        ctl_next.phase   = PH_RHIGH;
      end
      PH_RHIGH: begin
        ctl_next.pin_clk = 1'b1;
        ctl_next.phase   = PH_RLOW;
      end
      PH_RLOW: begin
        ctl_next.pin_clk = 1'b0;
        in_shift_next    = {in_shift[READ_BITS-2:0], serial_in};
        cnt_next         = cnt_inc;
        ctl_next.phase   = (cnt_inc >= CNT_W'(READ_BITS)) ? PH_THIGH : PH_RHIGH;
      end
      PH_THIGH: begin
        ctl_next.pin_clk = 1'b1;
        ctl_next.phase   = PH_TLOW;
      end
      PH_TLOW: begin
        ctl_next.pin_clk = 1'b0;
        ctl_next.phase   = PH_REND;
      end
      PH_REND: begin
        ctl_next.pin_le  = 1'b0;
        last_rb_next     = in_shift;
        ctl_next.pending = 1'b0;
        done             = 1'b1;
        ctl_next.phase   = PH_IDLE;
      end
      default: begin
        ctl_next.phase = PH_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[dv/tb.sv]
// Self-checking bench for three_wire_register_master_rssi_top: pin ticks are
// streamed in, every output beat is checked against a serial pin model or typed-in pins.
// Depends on twrm_pkg and the top-level RTL.
`timescale 1ns / 1ps

module tb;
  import twrm_pkg::*;

  // Operation code with no meaning; the block must treat it as an idle tick
  localparam logic [OP_W-1:0] OP_RSVD = 2'd3;
  // Tick index, counted from the start beat, of the first sampled readback bit
  localparam int FIRST_SAMPLE = 2 * WORD_BITS_DEF + 9;
  localparam int RANDOM_BEATS = 130;
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef enum int {SI_LOW, SI_HIGH, SI_RAND, SI_PAT} si_mode_t;

  typedef struct packed {
    logic                    sclk;
    logic                    sdata;
    logic                    latch;
    logic                    busy;
    logic                    done;
    logic [FIELD_READ_W-1:0] raw;
    logic [RSSI_W-1:0]       rssi;
  } pins_t;

  typedef struct {
    logic [OP_W-1:0]         op;
    logic [FIELD_WORD_W-1:0] word;
    logic [SEL_W-1:0]        sel;
    si_mode_t                mode;
    logic [FIELD_READ_W-1:0] pat;
    logic [OP_W-1:0]         filler;
    bit                      noisy;
    bit                      fix_on;
    pins_t                   fix;
  } seq_row_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = OP_IDLE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  // Typed-in expectation travelling alongside the beat on offer
  bit          beat_fix_on = 1'b0;
  pins_t       beat_fix    = '0;

  pins_t       pin_expect_q[$];
  seq_row_t    seq_table[$];
  int          n_err      = 0;
  int          n_got      = 0;
  int          beats_sent = 0;
  int          calm_left  = 0;
  int unsigned cycles     = 0;

  // Pin model state
  phase_t                  mdl_phase;
  logic [5:0]              mdl_cnt;
  logic [FIELD_WORD_W-1:0] mdl_out;
  logic [FIELD_READ_W-1:0] mdl_in;
  logic                    mdl_pend;
  logic [FIELD_READ_W-1:0] mdl_last;
  logic                    mdl_clk, mdl_data, mdl_le;

  three_wire_register_master_rssi_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost beat ends up here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [RSSI_W-1:0] rssi_from_raw(input logic [FIELD_READ_W-1:0] raw);
    logic [15:0] dbl;
    logic [8:0]  gain;
    logic [8:0]  sum;
    // Double, then add the gain correction picked by bits 11..8
    dbl = {raw[14:0], 1'b0};
    case (dbl[11:8])
      4'd0:    gain = 9'(2 * 86);
      4'd4:    gain = 9'(2 * 58);
      4'd5:    gain = 9'(2 * 38);
      4'd6:    gain = 9'(2 * 24);
      default: gain = 9'd0;
    endcase
    sum = {1'b0, dbl[7:0]} + gain;
    return sum[8:2];
  endfunction

  function automatic pins_t quiet_pins(input logic [FIELD_READ_W-1:0] raw,
                                       input logic [RSSI_W-1:0] rssi);
    pins_t p;
    p      = '0;
    p.raw  = raw;
    p.rssi = rssi;
    return p;
  endfunction

  // Ticks from the start beat up to and including the done tick
  function automatic int seq_ticks(input logic [OP_W-1:0] op);
    if (op == OP_WRITE) return 2 * WORD_BITS_DEF + 5;
    if (op == OP_READ) return 2 * WORD_BITS_DEF + 5 + 2 * READ_BITS_DEF + 6;
    return 1;
  endfunction

  task automatic reset_pin_model();
    mdl_phase = PH_IDLE;
    mdl_cnt   = '0;
    mdl_out   = '0;
    mdl_in    = '0;
    mdl_pend  = 1'b0;
    mdl_last  = '0;
    mdl_clk   = 1'b0;
    mdl_data  = 1'b0;
    mdl_le    = 1'b0;
  endtask

  // Advance the serial pin model by one tick and return the pins after it
  task automatic advance_pin_model(input logic [OP_W-1:0] op,
                                   input logic [FIELD_WORD_W-1:0] word,
                                   input logic [SEL_W-1:0] sel,
                                   input logic si,
                                   output pins_t r);
    phase_t cur;
    phase_t nxt;
    logic   dn;
    cur = mdl_phase;
    nxt = PH_IDLE;
    dn  = 1'b0;
    // Start only from idle; an operation offered while busy is dropped
    if (cur == PH_IDLE && (op == OP_WRITE || op == OP_READ)) begin
      if (op == OP_WRITE) begin
        mdl_out  = word;
        mdl_pend = 1'b0;
      end else begin
        mdl_out  = {23'd0, sel, SEL_TAIL};
        mdl_pend = 1'b1;
      end
      mdl_cnt = '0;
      cur     = PH_WLOW;
    end
    case (cur)
      PH_WLOW: begin
        mdl_clk  = 1'b0;
        mdl_data = mdl_out[WORD_BITS_DEF-1];
        nxt      = PH_WHIGH;
      end
      PH_WHIGH: begin
        mdl_clk = 1'b1;
        mdl_out = mdl_out << 1;
        mdl_cnt = mdl_cnt + 6'd1;
        nxt     = (mdl_cnt >= 6'(WORD_BITS_DEF)) ? PH_WEND : PH_WLOW;
      end
      PH_WEND: begin
        mdl_clk = 1'b0;
        nxt     = PH_LAT1;
      end
      PH_LAT1, PH_LAT2: begin
        mdl_le = 1'b1;
        nxt    = (cur == PH_LAT1) ? PH_LAT2 : PH_LAT3;
      end
      PH_LAT3: begin
        mdl_data = 1'b0;
        nxt      = PH_LAT4;
      end
      PH_LAT4: begin
        mdl_le = 1'b0;
        if (mdl_pend) begin
          nxt = PH_RSET;
        end else begin
          dn = 1'b1;
        end
      end
      PH_RSET: begin
        mdl_data = 1'b0;
        mdl_clk  = 1'b0;
        mdl_le   = 1'b1;
        mdl_in   = '0;
        mdl_cnt  = '0;
        nxt      = PH_DHIGH;
      end
      PH_DHIGH: begin
        mdl_clk = 1'b1;
        nxt     = PH_DLOW;
      end
      PH_DLOW: begin
        mdl_clk = 1'b0;
        nxt     = PH_RHIGH;
      end
      PH_RHIGH: begin
        mdl_clk = 1'b1;
        nxt     = PH_RLOW;
      end
      PH_RLOW: begin
        // Sample on the falling clock, MSB first
        mdl_clk = 1'b0;
        mdl_in  = {mdl_in[FIELD_READ_W-2:0], si};
        mdl_cnt = mdl_cnt + 6'd1;
        nxt     = (mdl_cnt >= 6'(READ_BITS_DEF)) ? PH_THIGH : PH_RHIGH;
      end
      PH_THIGH: begin
        mdl_clk = 1'b1;
        nxt     = PH_TLOW;
      end
      PH_TLOW: begin
        mdl_clk = 1'b0;
        nxt     = PH_REND;
      end
      PH_REND: begin
        mdl_le   = 1'b0;
        mdl_last = mdl_in;
        mdl_pend = 1'b0;
        dn       = 1'b1;
      end
      default: nxt = PH_IDLE;
    endcase
    mdl_phase = nxt;
    r.sclk  = mdl_clk;
    r.sdata = mdl_data;
    r.latch = mdl_le;
    r.busy  = (nxt != PH_IDLE);
    r.done  = dn;
    r.raw   = mdl_last;
    r.rssi  = rssi_from_raw(mdl_last);
  endtask

  task automatic compare_pins(input pins_t got, input pins_t want);
    if (got.sclk !== want.sclk) begin
      $error("serial_clock: expected %0d, got %0d", want.sclk, got.sclk);
      n_err++;
    end
    if (got.sdata !== want.sdata) begin
      $error("serial_data: expected %0d, got %0d", want.sdata, got.sdata);
      n_err++;
    end
    if (got.latch !== want.latch) begin
      $error("latch_enable: expected %0d, got %0d", want.latch, got.latch);
      n_err++;
    end
    if (got.busy !== want.busy) begin
      $error("busy_res: expected %0d, got %0d", want.busy, got.busy);
      n_err++;
    end
    if (got.done !== want.done) begin
      $error("done_res: expected %0d, got %0d", want.done, got.done);
      n_err++;
    end
    if (got.raw !== want.raw) begin
      $error("readback_raw: expected %h, got %h", want.raw, got.raw);
      n_err++;
    end
    if (got.rssi !== want.rssi) begin
      $error("signal_level: expected %0d, got %0d", want.rssi, got.rssi);
      n_err++;
    end
  endtask

  // Score both sides at the edge: take the accepted input beat into the model
  // first, then match any output beat against the oldest expectation.
  always @(posedge clk) begin : scoreboard
    pins_t want;
    pins_t got;
    if (rst) begin
      reset_pin_model();
    end else begin
      if (s_tvalid && s_tready) begin
        advance_pin_model(s_tuser, s_tdata[31:0], s_tdata[36:32], s_tdata[37], want);
        if (beat_fix_on) want = beat_fix;
        pin_expect_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got.sclk  = m_tdata[0];
        got.sdata = m_tdata[1];
        got.latch = m_tdata[2];
        got.busy  = m_tdata[3];
        got.done  = m_tdata[4];
        got.raw   = m_tdata[20:5];
        got.rssi  = m_tdata[27:21];
        n_got++;
        if (pin_expect_q.size() == 0) begin
          $error("output beat with no expectation pending: %h", m_tdata);
          n_err++;
        end else begin
          compare_pins(got, pin_expect_q.pop_front());
        end
      end
    end
  end

  // Offer one tick; wait out a random gap first, then hold until accepted
  task automatic drive_beat(input logic [OP_W-1:0] op, input logic [FIELD_WORD_W-1:0] word,
                            input logic [SEL_W-1:0] sel, input logic si,
                            input bit fix_on, input pins_t fix);
    int gap;
    int r;
    gap = 0;
    if (calm_left > 0) begin
      calm_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 2) calm_left = 80;
      if (r >= 55 && r < 92) gap = $urandom_range(1, 3);
      else if (r >= 92) gap = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid    <= 1'b1;
    s_tuser     <= op;
    s_tdata     <= {2'b00, si, sel, word};
    beat_fix_on <= fix_on;
    beat_fix    <= fix;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    beats_sent++;
  endtask

  // Stream one sequence: the start beat, filler ticks, then idle ticks
  task automatic run_sequence(input seq_row_t row, input int length, input int fill_end);
    logic [OP_W-1:0] k_op;
    logic            si;
    int              k;
    for (k = 0; k < length; k++) begin
      if (k == 0) k_op = row.op;
      else if (k < fill_end) k_op = row.noisy ? OP_W'($urandom_range(0, 3)) : row.filler;
      else k_op = OP_IDLE;
      case (row.mode)
        SI_LOW:  si = 1'b0;
        SI_HIGH: si = 1'b1;
        default: si = 1'($urandom_range(0, 1));
      endcase
      // Line the pattern up with the falling-edge sample ticks of a readback
      if (row.mode == SI_PAT && row.op == OP_READ && k >= FIRST_SAMPLE &&
          k < FIRST_SAMPLE + 2 * READ_BITS_DEF && ((k - FIRST_SAMPLE) % 2) == 0)
        si = row.pat[READ_BITS_DEF - 1 - (k - FIRST_SAMPLE) / 2];
      drive_beat(k_op, (k == 0) ? row.word : $urandom(),
                 (k == 0) ? row.sel : SEL_W'($urandom_range(0, 31)), si,
                 row.fix_on && (k == length - 1), row.fix);
    end
  endtask

  task automatic add_row(input logic [OP_W-1:0] op, input logic [FIELD_WORD_W-1:0] word,
                         input logic [SEL_W-1:0] sel, input si_mode_t mode,
                         input logic [FIELD_READ_W-1:0] pat, input logic [OP_W-1:0] filler,
                         input bit noisy, input bit fix_on, input pins_t fix);
    seq_row_t row;
    row.op     = op;
    row.word   = word;
    row.sel    = sel;
    row.mode   = mode;
    row.pat    = pat;
    row.filler = filler;
    row.noisy  = noisy;
    row.fix_on = fix_on;
    row.fix    = fix;
    seq_table.push_back(row);
  endtask

  // Sink: ready in runs with gaps, once a long hold-off so the block backs up
  initial begin : sink
    int run;
    int gap;
    int r;
    bit held;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      run = $urandom_range(1, 12);
      r   = $urandom_range(0, 99);
      if (r < 40) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 60);
      if (r < 4) begin
        run = 200;
        gap = 0;
      end
      if (!held && n_got >= HOLD_AFTER) begin
        held = 1'b1;
        run  = 1;
        gap  = HOLD_CYCLES;
      end
      m_tready <= 1'b1;
      repeat (run) @(posedge clk);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : source
    seq_row_t  row;
    int        n;
    int        r;
    int        dir_beats;
    logic [OP_W-1:0] op;

    // Directed sequences: idle ticks, the reserved code, a word extreme,
    // operations offered while busy, readback extremes and a gain-table hit
    add_row(OP_IDLE,  32'h0,        5'd0,  SI_LOW,  16'h0,    OP_IDLE,  0, 1,
            quiet_pins(16'h0000, 7'd43));
    add_row(OP_RSVD,  32'hFFFFFFFF, 5'd31, SI_HIGH, 16'h0,    OP_IDLE,  0, 1,
            quiet_pins(16'h0000, 7'd43));
    add_row(OP_WRITE, 32'hFFFFFFFF, 5'd31, SI_HIGH, 16'h0,    OP_WRITE, 0, 1,
            quiet_pins(16'h0000, 7'd43));
    add_row(OP_READ,  32'hFFFFFFFF, 5'd0,  SI_LOW,  16'h0,    OP_READ,  0, 1,
            quiet_pins(16'h0000, 7'd43));
    add_row(OP_READ,  32'h0,        5'd31, SI_HIGH, 16'h0,    OP_RSVD,  0, 1,
            quiet_pins(16'hFFFF, 7'd63));
    add_row(OP_READ,  32'h0,        5'd5,  SI_PAT,  16'h0280, OP_IDLE,  1, 0, '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Walk the table; filler stops well inside the busy window
    foreach (seq_table[i]) begin
      n = seq_ticks(seq_table[i].op);
      run_sequence(seq_table[i], n + 4, n - 4);
    end
    dir_beats = beats_sent;

    // Random sequences: mostly well formed, some cut short or full of noise
    while (beats_sent < dir_beats + RANDOM_BEATS) begin
      r = $urandom_range(0, 99);
      if (r < 45) op = OP_READ;
      else if (r < 85) op = OP_WRITE;
      else if (r < 93) op = OP_IDLE;
      else op = OP_RSVD;
      row.op     = op;
      row.word   = $urandom();
      row.sel    = SEL_W'($urandom_range(0, 31));
      row.pat    = FIELD_READ_W'($urandom());
      row.filler = OP_IDLE;
      row.fix_on = 1'b0;
      row.fix    = '0;
      r = $urandom_range(0, 99);
      if (r < 20) row.mode = SI_PAT;
      else if (r < 26) row.mode = SI_LOW;
      else if (r < 32) row.mode = SI_HIGH;
      else row.mode = SI_RAND;
      n = seq_ticks(op);
      if ($urandom_range(0, 99) < 80) begin
        row.noisy = ($urandom_range(0, 99) < 25);
        run_sequence(row, n + $urandom_range(0, 3), n - 1);
      end else begin
        row.noisy = 1'b1;
        r = $urandom_range(1, n + 10);
        run_sequence(row, r, r);
      end
    end
    s_tvalid <= 1'b0;

    // Drain the expectations, then let the output register settle
    while (pin_expect_q.size() != 0 || n_got < beats_sent) @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
rtl/twrm_pkg.sv
rtl/twrm_rssi.sv
rtl/twrm_step.sv
rtl/three_wire_register_master_rssi_top.sv
dv/tb.sv
